@@ rtl/core/fbc_pkg.sv @@
`default_nettype none

package fbc_pkg;

   localparam int STAGES_DEFAULT = 4;
   localparam int TAPS_DEFAULT   = 64;

   localparam int FRAC_BITS = 27;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 32;
   // Largest biquad output before it is added to the running result.
   localparam int Y_W       = 22;
   localparam int PROD_W    = COEF_W + Y_W;
   // Wide enough for up to 256 products of a sample and a coefficient.
   localparam int ACC_W     = 56;
   localparam int DELAY_W   = 48;
   localparam int RES_W     = 32;

   typedef enum logic [1:0] {
      OP_SAMPLE  = 2'd0,
      OP_FIR_TAP = 2'd1,
      OP_MODE    = 2'd2,
      OP_BQ_COEF = 2'd3
   } op_type;

   localparam logic [1:0] KIND_OFF      = 2'd0;
   localparam logic [1:0] KIND_FIR      = 2'd1;
   localparam logic [1:0] KIND_BIQUAD   = 2'd2;
   // The unused kind code; a stage holding it counts as off.
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   localparam logic [2:0] COEF_A0 = 3'd0;
   localparam logic [2:0] COEF_A1 = 3'd1;
   localparam logic [2:0] COEF_A2 = 3'd2;
   localparam logic [2:0] COEF_B1 = 3'd3;
   localparam logic [2:0] COEF_B2 = 3'd4;

   typedef struct packed {
      logic       from_sample;
      logic       accumulate;
      logic [1:0] kind;
   } mode_type;

   typedef struct packed {
      logic                     en;
      logic signed [COEF_W-1:0] a;
      logic signed [Y_W-1:0]    b;
   } mul_req_type;

endpackage

`default_nettype wire

@@ rtl/core/fbc_channels.sv @@
`default_nettype none

interface fbc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [15:0] sample;
   logic [1:0]         stage;
   logic [5:0]         tap_index;
   logic [2:0]         coef_select;
   logic signed [31:0] coef_value;
   logic [1:0]         stage_kind;
   logic               accumulate;
   logic               from_sample;

   modport source (output valid, operation, sample, stage, tap_index, coef_select,
                   coef_value, stage_kind, accumulate, from_sample, input ready);
   modport sink (input valid, operation, sample, stage, tap_index, coef_select,
                 coef_value, stage_kind, accumulate, from_sample, output ready);
endinterface

interface fbc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] result;
   logic               clipped;

   modport source (output valid, result, clipped, input ready);
   modport sink (input valid, result, clipped, output ready);
endinterface

`default_nettype wire

@@ rtl/core/fir_biquad_filter_chain_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake      Carries
// req_chan  in         valid/ready    sample items and table write items
// rsp_chan  out        valid/ready    one filtered sample per sample item
//
// The unit takes a new item only when idle. A sample item walks the stages
// in order, and every FIR tap and biquad coefficient goes through the
// single shared multiplier.
// After reset a clearing pass zeroes the FIR, history, biquad and delay
// memories; no transaction is accepted during it.
// The result register lets the next transaction in while a result waits;
// a finished sample stalls only when the previous result is still not taken.
module fir_biquad_filter_chain_unit #(
   parameter int STAGES = fbc_pkg::STAGES_DEFAULT,
   parameter int TAPS   = fbc_pkg::TAPS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fbc_req_if.sink    req_chan,
   fbc_rsp_if.source  rsp_chan
);

   localparam int FirDepth = STAGES * TAPS;
   localparam int FirAw    = $clog2(FirDepth);
   localparam int HistLen  = TAPS - 1;
   localparam int HistAw   = $clog2(HistLen);
   localparam int BqDepth  = STAGES * 5;
   localparam int BqAw     = $clog2(BqDepth);
   localparam int StW      = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int StCntW   = $clog2(STAGES + 1);
   localparam int TapW     = $clog2(TAPS + 1);
   localparam int ClrN     = (FirDepth > BqDepth) ? FirDepth : BqDepth;
   localparam int ClrW     = $clog2(ClrN);
   localparam int RowW     = 2 * fbc_pkg::DELAY_W;

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_STAGE    = 8'b0000_0100,
      ST_FIR      = 8'b0000_1000,
      ST_BQ_ISSUE = 8'b0001_0000,
      ST_BQ_MUL   = 8'b0010_0000,
      ST_BQ_ACC   = 8'b0100_0000,
      ST_FINISH   = 8'b1000_0000
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
      logic signed [47:0] r;
      if (v[55:47] == {9{v[55]}}) begin
         r = v[47:0];
      end else if (v[55]) begin
         r = {1'b1, 47'd0};
      end else begin
         r = {1'b0, {47{1'b1}}};
      end
      return r;
   endfunction

   // Control and datapath registers.
   state_type                      state_ff, state_in;
   logic [ClrW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic [StCntW-1:0]              stage_ff, stage_in;
   logic [TapW-1:0]                tap_ff, tap_in;
   logic [HistAw-1:0]              hp_ff, hp_in;
   logic [HistAw-1:0]              wp_ff, wp_in;
   logic                           v1_ff, v1_in;
   logic                           c1_ff, c1_in;
   logic                           v2_ff, v2_in;
   logic signed [fbc_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0]             res_ff, res_in;
   logic signed [15:0]             x_ff, x_in;
   logic signed [15:0]             xin_ff, xin_in;
   logic [2:0]                     k_ff, k_in;
   logic signed [fbc_pkg::Y_W-1:0] y_ff, y_in;
   logic signed [55:0]             t1_ff, t1_in;
   logic signed [55:0]             t2_ff, t2_in;
   logic signed [47:0]             nz1_ff, nz1_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]             rsp_result_ff, rsp_result_in;
   logic                           rsp_clipped_ff, rsp_clipped_in;
   fbc_pkg::mode_type              modes_ff [STAGES];
   fbc_pkg::mode_type              mode_in;
   logic                           mode_we;
   logic [StW-1:0]                 mode_wst;

   // Memories and their registered read data.
   logic signed [31:0]  fir_mem  [FirDepth];
   logic signed [15:0]  hist_mem [HistLen];
   logic signed [31:0]  bq_mem   [BqDepth];
   logic [RowW-1:0]     dly_mem  [STAGES];
   logic signed [31:0]  fir_rd_ff;
   logic signed [15:0]  hist_rd_ff;
   logic signed [31:0]  bq_rd_ff;
   logic [RowW-1:0]     dly_rd_ff;

   logic                fir_we, fir_re, hist_we, hist_re, bq_we, bq_re, dly_we, dly_re;
   logic [FirAw-1:0]    fir_waddr, fir_raddr;
   logic [HistAw-1:0]   hist_waddr, hist_raddr;
   logic [BqAw-1:0]     bq_waddr, bq_raddr;
   logic [StW-1:0]      dly_waddr, dly_raddr;
   logic signed [31:0]  fir_wdata, bq_wdata;
   logic signed [15:0]  hist_wdata;
   logic [RowW-1:0]     dly_wdata;

   fbc_pkg::mul_req_type                mreq;
   logic signed [fbc_pkg::PROD_W-1:0]   prod_ff;
   logic signed [55:0]                  prod_x;
   logic signed [55:0]                  z1_x;
   logic signed [55:0]                  z2_x;
   logic signed [55:0]                  ysum;
   logic signed [fbc_pkg::ACC_W-1:0]    acc_sh;
   fbc_pkg::mode_type                   mode_cur;
   logic                                stage_live;
   logic                                req_accept;
   logic                                st_ok;

   fbc_mul u_mul (
      .clock   (clock),
      .mreq    (mreq),
      .prod_ff (prod_ff)
   );

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_accept       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.result  = rsp_result_ff;
   assign rsp_chan.clipped = rsp_clipped_ff;

   assign mode_cur   = modes_ff[stage_ff[StW-1:0]];
   assign stage_live = (32'(stage_ff) < STAGES) &&
                       ((mode_cur.kind == fbc_pkg::KIND_FIR) ||
                        (mode_cur.kind == fbc_pkg::KIND_BIQUAD));
   assign st_ok      = (32'(req_chan.stage) < STAGES);

   assign prod_x = {{(56 - fbc_pkg::PROD_W){prod_ff[fbc_pkg::PROD_W-1]}}, prod_ff};
   assign z1_x   = {{8{dly_rd_ff[RowW-1]}}, dly_rd_ff[RowW-1:fbc_pkg::DELAY_W]};
   assign z2_x   = {{8{dly_rd_ff[fbc_pkg::DELAY_W-1]}}, dly_rd_ff[fbc_pkg::DELAY_W-1:0]};
   assign ysum   = prod_x + z1_x;
   assign acc_sh = acc_ff >>> fbc_pkg::FRAC_BITS;

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      stage_in       = stage_ff;
      tap_in         = tap_ff;
      hp_in          = hp_ff;
      wp_in          = wp_ff;
      v1_in          = 1'b0;
      c1_in          = c1_ff;
      v2_in          = 1'b0;
      acc_in         = acc_ff;
      res_in         = res_ff;
      x_in           = x_ff;
      xin_in         = xin_ff;
      k_in           = k_ff;
      y_in           = y_ff;
      t1_in          = t1_ff;
      t2_in          = t2_ff;
      nz1_in         = nz1_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_result_in  = rsp_result_ff;
      rsp_clipped_in = rsp_clipped_ff;
      mode_we        = 1'b0;
      mode_wst       = StW'(req_chan.stage);
      mode_in        = '{from_sample: req_chan.from_sample,
                         accumulate: req_chan.accumulate,
                         kind: req_chan.stage_kind};

      fir_we = 1'b0; fir_waddr = '0; fir_wdata = '0;
      fir_re = 1'b0; fir_raddr = FirAw'(32'(stage_ff) * TAPS + 32'(tap_ff));
      hist_we = 1'b0; hist_waddr = wp_ff; hist_wdata = x_ff;
      hist_re = 1'b0; hist_raddr = hp_ff;
      bq_we = 1'b0; bq_waddr = '0; bq_wdata = '0;
      bq_re = 1'b0; bq_raddr = BqAw'(32'(stage_ff) * 5 + 32'(k_ff));
      dly_we = 1'b0; dly_waddr = stage_ff[StW-1:0]; dly_wdata = '0;
      dly_re = 1'b0; dly_raddr = stage_ff[StW-1:0];

      mreq.en = 1'b0;
      mreq.a  = fir_rd_ff;
      mreq.b  = {{(fbc_pkg::Y_W - 16){hist_rd_ff[15]}}, hist_rd_ff};

      case (state_ff)
         ST_CLEAR: begin
            // Zero every entry of every memory, one address per cycle.
            fir_we     = (32'(clr_cnt_ff) < FirDepth);
            fir_waddr  = FirAw'(clr_cnt_ff);
            hist_we    = (32'(clr_cnt_ff) < HistLen);
            hist_waddr = HistAw'(clr_cnt_ff);
            hist_wdata = '0;
            bq_we      = (32'(clr_cnt_ff) < BqDepth);
            bq_waddr   = BqAw'(clr_cnt_ff);
            dly_we     = (32'(clr_cnt_ff) < STAGES);
            dly_waddr  = StW'(clr_cnt_ff);
            clr_cnt_in = clr_cnt_ff + ClrW'(1);
            if (32'(clr_cnt_ff) == ClrN - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.operation == fbc_pkg::OP_SAMPLE) begin
                  x_in     = req_chan.sample;
                  stage_in = '0;
                  res_in   = '0;
                  if ((modes_ff[0].kind == fbc_pkg::KIND_FIR) ||
                      (modes_ff[0].kind == fbc_pkg::KIND_BIQUAD)) begin
                     state_in = ST_STAGE;
                  end else begin
                     // Stage 0 off: the sample passes straight through.
                     res_in   = 32'(req_chan.sample);
                     state_in = ST_FINISH;
                  end
               end else if (st_ok) begin
                  case (req_chan.operation)
                     fbc_pkg::OP_FIR_TAP: begin
                        if (32'(req_chan.tap_index) < TAPS) begin
                           fir_we    = 1'b1;
                           fir_waddr = FirAw'(32'(req_chan.stage) * TAPS +
                                              32'(req_chan.tap_index));
                           fir_wdata = req_chan.coef_value;
                           dly_we    = 1'b1;
                        end
                     end
                     fbc_pkg::OP_MODE: begin
                        mode_we = 1'b1;
                        dly_we  = 1'b1;
                     end
                     fbc_pkg::OP_BQ_COEF: begin
                        if (req_chan.coef_select <= fbc_pkg::COEF_B2) begin
                           bq_we    = 1'b1;
                           bq_waddr = BqAw'(32'(req_chan.stage) * 5 +
                                            32'(req_chan.coef_select));
                           bq_wdata = req_chan.coef_value;
                           dly_we   = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
                  dly_waddr = StW'(req_chan.stage);
               end
            end
         end
         ST_STAGE: begin
            if (!stage_live) begin
               state_in = ST_FINISH;
            end else if (mode_cur.kind == fbc_pkg::KIND_FIR) begin
               tap_in   = '0;
               hp_in    = wp_ff;
               acc_in   = '0;
               state_in = ST_FIR;
            end else begin
               if ((stage_ff == '0) || mode_cur.from_sample) begin
                  xin_in = x_ff;
               end else begin
                  xin_in = sat16(res_ff);
               end
               k_in     = '0;
               dly_re   = 1'b1;
               state_in = ST_BQ_ISSUE;
            end
         end
         ST_FIR: begin
            // Three-deep pipeline: read, multiply, accumulate.
            if (32'(tap_ff) < TAPS) begin
               fir_re = 1'b1;
               if (32'(tap_ff) < TAPS - 1) begin
                  hist_re = 1'b1;
                  hp_in   = (32'(hp_ff) == HistLen - 1) ? '0 : hp_ff + HistAw'(1);
               end
               v1_in  = 1'b1;
               c1_in  = (32'(tap_ff) == TAPS - 1);
               tap_in = tap_ff + TapW'(1);
            end
            if (v1_ff) begin
               mreq.en = 1'b1;
               if (c1_ff) begin
                  mreq.b = {{(fbc_pkg::Y_W - 16){x_ff[15]}}, x_ff};
               end
               v2_in = 1'b1;
            end
            if (v2_ff) begin
               acc_in = acc_ff + fbc_pkg::ACC_W'(prod_x);
            end
            if ((32'(tap_ff) == TAPS) && !v1_ff && !v2_ff) begin
               res_in   = res_ff + acc_sh[31:0];
               stage_in = stage_ff + StCntW'(1);
               state_in = ST_STAGE;
            end
         end
         ST_BQ_ISSUE: begin
            bq_re    = 1'b1;
            state_in = ST_BQ_MUL;
         end
         ST_BQ_MUL: begin
            mreq.en = 1'b1;
            mreq.a  = bq_rd_ff;
            if (k_ff < fbc_pkg::COEF_B1) begin
               mreq.b = {{(fbc_pkg::Y_W - 16){xin_ff[15]}}, xin_ff};
            end else begin
               mreq.b = y_ff;
            end
            state_in = ST_BQ_ACC;
         end
         ST_BQ_ACC: begin
            k_in     = k_ff + 3'd1;
            state_in = ST_BQ_ISSUE;
            case (k_ff)
               fbc_pkg::COEF_A0: begin
                  y_in = ysum[fbc_pkg::FRAC_BITS + fbc_pkg::Y_W - 1:fbc_pkg::FRAC_BITS];
               end
               fbc_pkg::COEF_A1: begin
                  t1_in = prod_x + z2_x;
               end
               fbc_pkg::COEF_A2: begin
                  t2_in = prod_x;
               end
               fbc_pkg::COEF_B1: begin
                  nz1_in = sat48(t1_ff - prod_x);
               end
               default: begin
                  dly_we    = 1'b1;
                  dly_wdata = {nz1_ff, sat48(t2_ff - prod_x)};
                  if (mode_cur.accumulate) begin
                     res_in = res_ff + 32'(y_ff);
                  end else begin
                     res_in = 32'(y_ff);
                  end
                  stage_in = stage_ff + StCntW'(1);
                  state_in = ST_STAGE;
               end
            endcase
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_result_in  = sat16(res_ff);
               rsp_clipped_in = (res_ff > 32'sd32767) || (res_ff < -32'sd32768);
               // The sample enters the history ring over its oldest entry.
               hist_we  = 1'b1;
               wp_in    = (32'(wp_ff) == HistLen - 1) ? '0 : wp_ff + HistAw'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         for (int i = 0; i < STAGES; i++) begin
            modes_ff[i] <= '{from_sample: 1'b0, accumulate: 1'b0, kind: fbc_pkg::KIND_OFF};
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         if (mode_we) begin
            modes_ff[mode_wst] <= mode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_ff       <= stage_in;
      tap_ff         <= tap_in;
      hp_ff          <= hp_in;
      c1_ff          <= c1_in;
      acc_ff         <= acc_in;
      res_ff         <= res_in;
      x_ff           <= x_in;
      xin_ff         <= xin_in;
      k_ff           <= k_in;
      y_ff           <= y_in;
      t1_ff          <= t1_in;
      t2_ff          <= t2_in;
      nz1_ff         <= nz1_in;
      rsp_result_ff  <= rsp_result_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

   always_ff @(posedge clock) begin
      if (fir_we) begin
         fir_mem[fir_waddr] <= fir_wdata;
      end
      if (fir_re) begin
         fir_rd_ff <= fir_mem[fir_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_rd_ff <= hist_mem[hist_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (bq_we) begin
         bq_mem[bq_waddr] <= bq_wdata;
      end
      if (bq_re) begin
         bq_rd_ff <= bq_mem[bq_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_waddr] <= dly_wdata;
      end
      if (dly_re) begin
         dly_rd_ff <= dly_mem[dly_raddr];
      end
   end

   // A new result only appears out of the finishing step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finishing step");

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      32'(wp_ff) < HistLen)
      else $error("history write pointer out of range");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clipped_ff) |->
      (rsp_result_ff == 16'sh7fff || rsp_result_ff == 16'sh8000))
      else $error("clipped result is not at a limit");

   a_fir_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIR && v2_ff) |-> $past(v1_ff))
      else $error("FIR product without a preceding read");

endmodule

`default_nettype wire

@@ rtl/core/fbc_mul.sv @@
`default_nettype none

// Shared signed multiplier with a registered product.
module fbc_mul (
   input  wire logic                                 clock,
   input  wire fbc_pkg::mul_req_type                 mreq,
   output logic signed [fbc_pkg::PROD_W-1:0]         prod_ff
);

   logic signed [fbc_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mreq.a * mreq.b;

   always_ff @(posedge clock) begin
      if (mreq.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire
